### design/assert_macros.svh
// Assertion macros for the checker module of the positional list.
// Depends on nothing; PLI_ASSERT_CLK takes the clock and reset names, PLI_ASSERT uses i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the given active-low reset is asserted.
`define PLI_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("positional list assertion failed");

// Same, on the usual clock and reset names of this block.
`define PLI_ASSERT(lbl, prop) `PLI_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

### design/pli_pkg.sv
// Package of the positional list: capacity, widths, codes and the transfer types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pli_pkg;

    localparam int CAPACITY  = 256;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int POS_W     = 9;
    localparam int CNT_OUT_W = 9;
    localparam int WORD_W    = 32;
    localparam int CMP_W     = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
    localparam int TREE_GRP  = 16;
    localparam int NGRP      = (CAPACITY + TREE_GRP - 1) / TREE_GRP;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic                     op;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] insert_value;
    } t_in;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] removed_value;
        logic [CNT_OUT_W-1:0]     count_after;
    } t_out;

    // Broadcast to every cell in the cycle of a transfer.
    typedef struct packed {
        logic             acc;   // request taken this cycle
        logic             ins;   // successful insert
        logic             del;   // successful delete
        logic [IDX_W-1:0] k;     // 0-based target slot
        t_word            value; // element to store on insert
    } t_cell_ctl;

endpackage

`default_nettype wire

### design/pli_cell.sv
// One slot of the list: holds an element and shifts with its neighbors.
// Depends on pli_pkg.
`default_nettype none

module pli_cell (
    input  wire                 i_clk,
    input  pli_pkg::t_cell_ctl  i_ctl,
    input  wire [pli_pkg::IDX_W-1:0] i_idx,
    input  pli_pkg::t_word      i_prev,
    input  pli_pkg::t_word      i_next,
    output pli_pkg::t_word      o_slot,
    output pli_pkg::t_word      o_tap
);
    import pli_pkg::*;

    t_word r_slot;
    t_word n_slot;
    t_word r_tap;
    logic  w_at;
    logic  w_above;

    assign w_at    = (i_idx == i_ctl.k);
    assign w_above = (i_idx > i_ctl.k);

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.ins) begin
            if (w_above) begin
                n_slot = i_prev;
            end else if (w_at) begin
                n_slot = i_ctl.value;
            end
        end else if (i_ctl.del) begin
            if (w_above || w_at) begin
                n_slot = i_next;
            end
        end
    end

    // Slots need no reset: only entries below the count are ever read.
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (i_ctl.acc) begin
            r_tap <= (i_ctl.del && w_at) ? r_slot : '0;
        end
    end

    assign o_slot = r_slot;
    assign o_tap  = r_tap;

endmodule

`default_nettype wire

### design/positional_list_insert_delete.sv
// Positional list with insert and delete by 1-based position. Each of the
// CAPACITY (256) slots is a cell that holds one signed 32-bit element; an
// insert at position p moves every cell from p upward one place and loads
// the value at p, a delete at p moves every cell from p upward down one
// place, all in the single cycle of the input transfer. Every request gives
// exactly one result: status (ok, position out of range, list full), the
// element removed by a successful delete (else zero) and the count after
// the request. The position is checked before fullness. One request is in
// flight at a time: a result appears on the output once the removed element
// has been read. The selected cell's tap is captured at the transfer, then
// gathered through a two-level registered OR tree (groups of 16 cells, then
// the groups). A new request is taken in the cycle its predecessor's result
// is transferred, so the block takes no new request while one is in flight
// or its result is held by an output stall. No clearing pass is needed
// after reset; the list comes up empty.
// Depends on pli_pkg and pli_cell.
`default_nettype none

module positional_list_insert_delete (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_stall,
    input  pli_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  wire           i_out_stall,
    output pli_pkg::t_out o_out_data
);
    import pli_pkg::*;

    // Pipeline control: taps captured, groups captured, result shown.
    logic r_s1;
    logic r_s2;
    logic r_out_vld;

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [1:0]           r_status;
    logic [1:0]           n_status;
    logic [CNT_OUT_W-1:0] r_cnt_after;
    t_word                r_removed;

    logic w_in_acc;
    logic w_out_acc;

    logic [CMP_W-1:0] w_pos_e;
    logic [CMP_W-1:0] w_cnt_e;
    logic [CMP_W-1:0] w_k_e;
    logic             w_full;
    logic             w_ins_ok;
    logic             w_del_ok;
    t_cell_ctl        w_ctl;

    t_word w_slot [CAPACITY];
    t_word w_tap  [CAPACITY];
    t_word w_grp  [NGRP];
    t_word r_grp  [NGRP];
    t_word w_all;

    // Take a new request once the previous result leaves the output.
    assign w_out_acc  = r_out_vld && !i_out_stall;
    assign o_in_stall = !i_rst_n || r_s1 || r_s2 || (r_out_vld && i_out_stall);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Range and fullness checks, done on a common wide compare width.
    assign w_pos_e = CMP_W'(i_in_data.position);
    assign w_cnt_e = CMP_W'(r_count);
    assign w_k_e   = w_pos_e - CMP_W'(1);
    assign w_full  = (w_cnt_e == CMP_W'(CAPACITY));

    always_comb begin
        w_ins_ok = 1'b0;
        w_del_ok = 1'b0;
        n_status = ST_RANGE;
        n_count  = r_count;
        case (i_in_data.op)
            OP_INSERT: begin
                if (w_pos_e != '0 && w_pos_e <= w_cnt_e + CMP_W'(1)) begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_OK;
                        w_ins_ok = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
            end
            OP_DELETE: begin
                if (w_pos_e != '0 && w_pos_e <= w_cnt_e) begin
                    n_status = ST_OK;
                    w_del_ok = 1'b1;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_RANGE;
            end
        endcase
    end

    // Broadcast one control word to the whole row of cells.
    assign w_ctl.acc   = w_in_acc;
    assign w_ctl.ins   = w_in_acc && w_ins_ok;
    assign w_ctl.del   = w_in_acc && w_del_ok;
    assign w_ctl.k     = w_k_e[IDX_W-1:0];
    assign w_ctl.value = t_word'(i_in_data.insert_value);

    // Row of cells; each sees its lower and upper neighbor.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_word w_prev;
        t_word w_next;
        if (gi == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_lo
            assign w_prev = w_slot[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_hi
            assign w_next = w_slot[gi+1];
        end
        pli_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_idx  (IDX_W'(gi)),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_slot (w_slot[gi]),
            .o_tap  (w_tap[gi])
        );
    end

    // First tree level: OR the taps of each group of cells. At most one tap
    // is nonzero, so the OR picks the removed element.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_grp[g] = '0;
            for (int j = 0; j < TREE_GRP; j++) begin
                if (g * TREE_GRP + j < CAPACITY) begin
                    w_grp[g] = w_grp[g] | w_tap[g * TREE_GRP + j];
                end
            end
        end
    end

    // Second tree level: OR the registered groups.
    always_comb begin
        w_all = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_all = w_all | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1) begin
            r_grp <= w_grp;
        end
        if (r_s2) begin
            r_removed <= w_all;
        end
        if (w_in_acc) begin
            r_status    <= n_status;
            r_cnt_after <= CNT_OUT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_s1      <= 1'b0;
            r_s2      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1 <= w_in_acc;
            r_s2 <= r_s1;
            if (w_in_acc) begin
                r_count <= n_count;
            end
            // Advance to the output; drop it once transferred.
            if (r_s2) begin
                r_out_vld <= 1'b1;
            end else if (w_out_acc) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid              = r_out_vld;
    assign o_out_data.status        = r_status;
    assign o_out_data.removed_value = signed'(r_removed);
    assign o_out_data.count_after   = r_cnt_after;

endmodule

`default_nettype wire

### design/pli_checker.sv
// Port-level checker for the positional list, bound to the top level.
// Depends on pli_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pli_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           i_in_valid,
    input wire           o_in_stall,
    input pli_pkg::t_in  i_in_data,
    input wire           o_out_valid,
    input wire           i_out_stall,
    input pli_pkg::t_out o_out_data
);
    import pli_pkg::*;

    // A stalled result holds.
    `PLI_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
    // Only one request in flight: a transfer in closes the input.
    `PLI_ASSERT(a_one_inflight, i_in_valid && !o_in_stall |=> o_in_stall)
    // The count never passes the capacity.
    `PLI_ASSERT(a_count_bound, o_out_valid |-> o_out_data.count_after <= CNT_OUT_W'(CAPACITY))
    // A failed request removes nothing.
    `PLI_ASSERT(a_fail_zero, o_out_valid && o_out_data.status != ST_OK |-> o_out_data.removed_value == 0)

endmodule

bind positional_list_insert_delete pli_checker u_pli_checker (.*);

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for positional_list_insert_delete: a directed opening, then
// biased random insert/delete traffic under varying idle and stall patterns.
// Depends on pli_pkg and the positional_list_insert_delete RTL.

module tb_top;

    import pli_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_LIMIT   = 5000;  // cycles with no transfer on either side
    localparam int SEGMENTS     = 8;
    localparam int SEG_ITEMS    = 200;
    localparam int REPORT_MAX   = 10;

    // Running copy of the list: predicts one reply per accepted request and
    // matches replies against the oldest prediction.
    class list_scoreboard;
        logic signed [WORD_W-1:0] slots [CAPACITY];
        int unsigned              held;
        t_out                     pending_replies [$];
        int unsigned              mismatches;
        int unsigned              requests;
        int unsigned              ins_ok;
        int unsigned              del_ok;
        int unsigned              range_errs;
        int unsigned              full_errs;
        int unsigned              peak;

        function void apply_request(t_in req);
            t_out        exp;
            int unsigned pos;
            int unsigned j;
            pos               = req.position;
            exp.status        = ST_OK;
            exp.removed_value = '0;
            requests++;
            if (req.op == OP_INSERT) begin
                if (pos < 1 || pos > held + 1) begin
                    exp.status = ST_RANGE;
                end else if (held >= CAPACITY) begin
                    exp.status = ST_FULL;
                end else begin
                    // open a hole at pos by moving the tail up one slot
                    for (j = held; j > pos - 1; j--)
                        slots[j] = slots[j-1];
                    slots[pos-1] = req.insert_value;
                    held++;
                    ins_ok++;
                end
            end else begin
                if (pos < 1 || pos > held) begin
                    exp.status = ST_RANGE;
                end else begin
                    exp.removed_value = slots[pos-1];
                    for (j = pos - 1; j + 1 < held; j++)
                        slots[j] = slots[j+1];
                    held--;
                    del_ok++;
                end
            end
            if (exp.status == ST_RANGE)
                range_errs++;
            if (exp.status == ST_FULL)
                full_errs++;
            if (held > peak)
                peak = held;
            exp.count_after = CNT_OUT_W'(held);
            pending_replies.push_back(exp);
        endfunction

        function void check_reply(t_out got);
            t_out exp;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: reply with nothing outstanding: ",
                             "status=%0d removed=%0d count=%0d",
                             got.status, got.removed_value, got.count_after);
                return;
            end
            exp = pending_replies.pop_front();
            if (got.status !== exp.status || got.removed_value !== exp.removed_value ||
                got.count_after !== exp.count_after) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: reply mismatch: exp status=%0d removed=%0d count=%0d, ",
                             exp.status, exp.removed_value, exp.count_after,
                             "got status=%0d removed=%0d count=%0d",
                             got.status, got.removed_value, got.count_after);
            end
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;

    int unsigned gap_pct   = 0;   // chance per cycle that the sender holds off
    int unsigned stall_pct = 0;   // chance per cycle that the receiver stalls
    int unsigned idle_cycles = 0;

    list_scoreboard board = new();

    positional_list_insert_delete u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Receiver side: draw a fresh stall decision every cycle.
    always @(negedge clk) begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Monitor both channels at the rising edge; also run the watchdog, which
    // restarts on every transfer and ends the run if traffic stops.
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall)
            board.apply_request(in_data);
        if (rst_n && out_valid && !out_stall)
            board.check_reply(out_data);
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles, %0d replies outstanding",
                     IDLE_LIMIT, board.pending_replies.size());
            $display("positional_list_insert_delete regression: fail");
            $finish;
        end
    end

    // Pick the idling pattern: none, sender only, receiver only, or both lightly.
    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 56; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 56; end
            default: begin gap_pct = 11; stall_pct = 11; end
        endcase
    endtask

    // Advance to the next falling edge, holding valid low for random idle cycles.
    task automatic wait_slot();
        @(negedge clk);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Present one request and hold it until the block takes it.
    task automatic transfer(t_in req);
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic issue(logic op, int unsigned pos, logic [WORD_W-1:0] value);
        t_in req;
        req.op           = op;
        req.position     = POS_W'(pos);
        req.insert_value = value;
        wait_slot();
        transfer(req);
    endtask

    // Drop valid and hold off until every outstanding reply has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending_replies.size() != 0)
            @(negedge clk);
    endtask

    // Random request against the current list length. Positions lean toward
    // the edges of the valid range (first, last, one past the end) with a
    // share of zero and far out-of-range values.
    function automatic t_in random_request(int unsigned ins_pct);
        t_in         req;
        int unsigned lim;
        int unsigned r;
        req.op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_DELETE;
        lim    = (req.op == OP_INSERT) ? board.held + 1 : board.held;
        r      = $urandom_range(99);
        if (r < 8)
            req.position = '0;
        else if (r < 14)
            req.position = (lim < 511) ? POS_W'($urandom_range(511, lim + 1)) : '0;
        else if (r < 20)
            req.position = POS_W'(lim + 1);
        else if (r < 32)
            req.position = POS_W'(1);
        else if (r < 44)
            req.position = POS_W'(lim);
        else
            req.position = (lim >= 1) ? POS_W'($urandom_range(lim, 1)) : POS_W'(1);
        case ($urandom_range(9))
            0: req.insert_value = 32'h8000_0000;
            1: req.insert_value = 32'h7fff_ffff;
            2: req.insert_value = 32'h0000_0000;
            3: req.insert_value = 32'hffff_ffff;
            default: req.insert_value = $urandom;
        endcase
        return req;
    endfunction

    // Insert share per random segment: fill to capacity, dwell at full,
    // drain to empty, dwell near empty, refill, then drain again.
    int unsigned ins_bias [SEGMENTS] = '{85, 85, 50, 15, 15, 50, 85, 30};

    initial begin
        set_idling(0);
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening: empty-list delete, position zero, positions past
        // the end, edge values, head/tail/middle inserts and deletes.
        issue(OP_DELETE, 1,   32'h1234_5678);
        issue(OP_DELETE, 0,   32'h0);
        issue(OP_INSERT, 0,   32'h0000_0001);
        issue(OP_INSERT, 2,   32'h0000_0002);
        issue(OP_INSERT, 511, 32'hffff_ffff);
        issue(OP_INSERT, 1,   32'h7fff_ffff);
        issue(OP_INSERT, 2,   32'h8000_0000);
        issue(OP_INSERT, 1,   32'hffff_ffff);
        issue(OP_INSERT, 2,   32'h0000_0000);
        issue(OP_INSERT, 6,   32'haaaa_aaaa);
        issue(OP_DELETE, 5,   32'h0);
        issue(OP_DELETE, 4,   32'h0);
        issue(OP_DELETE, 1,   32'h0);
        issue(OP_DELETE, 0,   32'h0);
        issue(OP_DELETE, 511, 32'h0);
        issue(OP_INSERT, 3,   32'h5555_5555);
        issue(OP_DELETE, 2,   32'h0);
        issue(OP_DELETE, 1,   32'h0);
        issue(OP_DELETE, 1,   32'h0);
        issue(OP_DELETE, 1,   32'hdead_beef);
        wait_drained();

        // Random segments, rotating the idling pattern; every other boundary
        // the sender holds off until all replies are in.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            set_idling(seg);
            for (int n = 0; n < SEG_ITEMS; n++) begin
                wait_slot();
                transfer(random_request(ins_bias[seg]));
            end
            if (seg % 2 == 1)
                wait_drained();
        end

        wait_drained();
        set_idling(0);
        repeat (8) @(posedge clk);

        $display("Covered %0d requests: %0d inserts and %0d deletes done, ",
                 board.requests, board.ins_ok, board.del_ok,
                 "%0d out of range, %0d on a full list.",
                 board.range_errs, board.full_errs);
        $display("List length peaked at %0d; %0d mismatching replies, %0d still outstanding.",
                 board.peak, board.mismatches, board.pending_replies.size());
        if (board.mismatches == 0 && board.pending_replies.size() == 0) begin
            $display("positional_list_insert_delete regression: pass");
        end else begin
            $display("positional_list_insert_delete regression: fail");
        end
        $finish;
    end

endmodule
